[src/reader_progress_percentile_rank_assert.svh]
// ----------------------------------------------------------------------------
// Reader progress percentile rank: assertion macros
// Shorthand for clocked properties on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef READER_PROGRESS_PERCENTILE_RANK_ASSERT_SVH
`define READER_PROGRESS_PERCENTILE_RANK_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define RPR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked from the cycle after the antecedent
`define RPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/rpr_pkg.sv]
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared constants, command codes and controller state type for the
// reader progress percentile rank block.
// ----------------------------------------------------------------------------
package rpr_pkg;

  // default sizes
  localparam int READER_SLOTS_DEF  = 131072;
  localparam int PAGE_SLOTS_DEF    = 1024;
  localparam int FRACTION_BITS_DEF = 20;

  // fixed field widths of an input item
  localparam int ID_W      = 17;
  localparam int PAGE_IN_W = 10;

  // command codes
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DEC,
    ST_INC_RD,
    ST_INC,
    ST_SUM,
    ST_DIV
  } rpr_state_t;

endpackage

[src/rpr_div.sv]
// ----------------------------------------------------------------------------
// rpr_div
// Restoring divider for the rank fraction: one quotient bit per cycle,
// FB + 1 bits, dividend known to be no larger than the divisor.
// ----------------------------------------------------------------------------
module rpr_div #(
  parameter int CW = 18,
  parameter int FB = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [CW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [FB:0]   quotient
);

  localparam int SW = $clog2(FB + 2);

  logic          running;
  logic [SW-1:0] steps;
  logic [CW:0]   rem;
  logic [CW-1:0] dsor;
  logic          ge;
  logic [CW:0]   rem_sub;

  // one trial subtraction
  always_comb begin
    ge      = rem >= {1'b0, dsor};
    rem_sub = ge ? rem - {1'b0, dsor} : rem;
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      steps   <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= SW'(FB + 1);
      end else if (running) begin
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, dividend};
      dsor <= divisor;
    end else if (running) begin
      rem      <= {rem_sub[CW-1:0], 1'b0};
      quotient <= {quotient[FB-1:0], ge};
    end
  end

endmodule

[src/reader_progress_percentile_rank.sv]
// Record item: busy stays high through LOOKUP, DEC, INC_RD and INC for a known reader,
// through LOOKUP and INC for a new one, and through LOOKUP alone for an out-of-range id.
// Query item: done is set from LOOKUP for an unknown or lone reader, otherwise after
// the histogram sweep over the bins below the reader's recorded page and the bit-serial
// divider; busy falls as done rises, never stalled. After reset a clearing pass over
// max(READER_SLOTS, PAGE_SLOTS) slots (131072 by default) runs with busy high before the first item.
// ----------------------------------------------------------------------------
// reader_progress_percentile_rank
// Per-reader page table and readers-per-page histogram in block memory;
// answers the share of other readers strictly behind a given reader.
// ----------------------------------------------------------------------------
module reader_progress_percentile_rank #(
  parameter int READER_SLOTS  = rpr_pkg::READER_SLOTS_DEF,
  parameter int PAGE_SLOTS    = rpr_pkg::PAGE_SLOTS_DEF,
  parameter int FRACTION_BITS = rpr_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command,
  input  logic [rpr_pkg::ID_W-1:0]      reader_id,
  input  logic [rpr_pkg::PAGE_IN_W-1:0] page_reached,
  output logic                         done,
  output logic [FRACTION_BITS:0]       rank_fraction
);

  import rpr_pkg::*;

  localparam int IW        = $clog2(READER_SLOTS);
  localparam int PW        = $clog2(PAGE_SLOTS);
  localparam int CW        = $clog2(READER_SLOTS + 1);
  localparam int RW        = PW + 1;
  localparam int CLR_SLOTS = (READER_SLOTS > PAGE_SLOTS) ? READER_SLOTS : PAGE_SLOTS;
  localparam int CLW       = $clog2(CLR_SLOTS);

  // reader table: {known, page}
  logic [RW-1:0] reader_mem [READER_SLOTS];
  logic          rmem_we;
  logic [IW-1:0] rmem_waddr, rmem_raddr;
  logic [RW-1:0] rmem_wdata, rmem_rdata;

  // readers-per-page histogram
  logic [CW-1:0] hist_mem [PAGE_SLOTS];
  logic          hist_we;
  logic [PW-1:0] hist_waddr, hist_raddr;
  logic [CW-1:0] hist_wdata, hist_rdata;

  // control registers
  rpr_state_t     state, state_next;
  logic [CLW-1:0] clr_cnt, clr_cnt_next;
  logic [CW-1:0]  total, total_next;
  logic           sum_pend, sum_pend_next;
  logic           done_next;

  // item and working registers
  logic             cmd_q, cmd_next;
  logic             id_ok_q, id_ok_next;
  logic [IW-1:0]    id_q, id_next;
  logic [PW-1:0]    page_q, page_next;
  logic [PW-1:0]    old_page_q, old_page_next;
  logic [CW-1:0]    acc, acc_next;
  logic [PW:0]      sum_cnt, sum_cnt_next;
  logic [FRACTION_BITS:0] frac_next;

  // input decode
  logic [31:0]   page_wide;
  logic [PW-1:0] page_in;
  logic          id_in_ok;
  logic          known;
  logic [CW-1:0] others, below;

  // divider link
  logic                   div_start;
  logic                   div_done;
  logic [FRACTION_BITS:0] div_quot;

  // memories
  always_ff @(posedge clk) begin
    if (rmem_we) begin
      reader_mem[rmem_waddr] <= rmem_wdata;
    end
    rmem_rdata <= reader_mem[rmem_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rdata <= hist_mem[hist_raddr];
  end

  // page saturation and id range check
  always_comb begin
    page_wide = 32'(page_reached);
    page_in   = (page_wide >= 32'(PAGE_SLOTS)) ? PW'(PAGE_SLOTS - 1) : PW'(page_wide);
    id_in_ok  = 32'(reader_id) < 32'(READER_SLOTS);
    known     = rmem_rdata[PW] && id_ok_q;
    others    = total - CW'(1);
    below     = (acc > others) ? others : acc;
  end

  assign busy = (state != ST_IDLE);

  // next state and memory controls
  always_comb begin
    state_next    = state;
    clr_cnt_next  = clr_cnt;
    total_next    = total;
    sum_pend_next = sum_pend;
    done_next     = 1'b0;
    cmd_next      = cmd_q;
    id_ok_next    = id_ok_q;
    id_next       = id_q;
    page_next     = page_q;
    old_page_next = old_page_q;
    acc_next      = acc;
    sum_cnt_next  = sum_cnt;
    frac_next     = rank_fraction;
    div_start     = 1'b0;
    rmem_we       = 1'b0;
    rmem_waddr    = id_q;
    rmem_wdata    = {1'b1, page_q};
    rmem_raddr    = IW'(reader_id);
    hist_we       = 1'b0;
    hist_waddr    = page_q;
    hist_wdata    = hist_rdata + CW'(1);
    hist_raddr    = sum_cnt[PW-1:0];

    unique case (state)
      // sweep both memories to zero
      ST_CLEAR: begin
        rmem_we    = 32'(clr_cnt) < 32'(READER_SLOTS);
        rmem_waddr = IW'(clr_cnt);
        rmem_wdata = '0;
        hist_we    = 32'(clr_cnt) < 32'(PAGE_SLOTS);
        hist_waddr = PW'(clr_cnt);
        hist_wdata = '0;
        if (32'(clr_cnt) == 32'(CLR_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + CLW'(1);
        end
      end

      // take an item, reader table read issued from the ports
      ST_IDLE: begin
        if (start) begin
          cmd_next   = command;
          id_ok_next = id_in_ok;
          id_next    = IW'(reader_id);
          page_next  = page_in;
          state_next = ST_LOOKUP;
        end
      end

      // reader table data is back
      ST_LOOKUP: begin
        old_page_next = rmem_rdata[PW-1:0];
        if (cmd_q == CMD_RECORD) begin
          if (!id_ok_q) begin
            state_next = ST_IDLE;
          end else if (known) begin
            hist_raddr = rmem_rdata[PW-1:0];
            state_next = ST_DEC;
          end else begin
            rmem_we    = 1'b1;
            total_next = total + CW'(1);
            hist_raddr = page_q;
            state_next = ST_INC;
          end
        end else begin
          if (!known) begin
            done_next  = 1'b1;
            frac_next  = '0;
            state_next = ST_IDLE;
          end else if (total <= CW'(1)) begin
            done_next  = 1'b1;
            frac_next  = {1'b1, {FRACTION_BITS{1'b0}}};
            state_next = ST_IDLE;
          end else begin
            acc_next      = '0;
            sum_cnt_next  = '0;
            sum_pend_next = 1'b0;
            state_next    = ST_SUM;
          end
        end
      end

      // old bin down by one, saturating; reader page updated
      ST_DEC: begin
        hist_we    = 1'b1;
        hist_waddr = old_page_q;
        hist_wdata = (hist_rdata == '0) ? '0 : hist_rdata - CW'(1);
        rmem_we    = 1'b1;
        state_next = ST_INC_RD;
      end

      // new bin read after the decrement has landed
      ST_INC_RD: begin
        hist_raddr = page_q;
        state_next = ST_INC;
      end

      // new bin up by one
      ST_INC: begin
        hist_we    = 1'b1;
        state_next = ST_IDLE;
      end

      // pipelined sweep over bins below the reader's page
      ST_SUM: begin
        if (sum_pend) begin
          acc_next = acc + hist_rdata;
        end
        if (sum_cnt != {1'b0, old_page_q}) begin
          hist_raddr    = sum_cnt[PW-1:0];
          sum_cnt_next  = sum_cnt + (PW + 1)'(1);
          sum_pend_next = 1'b1;
        end else begin
          sum_pend_next = 1'b0;
          if (!sum_pend) begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end
      end

      // wait for the quotient
      ST_DIV: begin
        if (div_done) begin
          done_next  = 1'b1;
          frac_next  = div_quot;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      total    <= '0;
      sum_pend <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_cnt  <= clr_cnt_next;
      total    <= total_next;
      sum_pend <= sum_pend_next;
      done     <= done_next;
    end
  end

  // item and working data
  always_ff @(posedge clk) begin
    cmd_q         <= cmd_next;
    id_ok_q       <= id_ok_next;
    id_q          <= id_next;
    page_q        <= page_next;
    old_page_q    <= old_page_next;
    acc           <= acc_next;
    sum_cnt       <= sum_cnt_next;
    rank_fraction <= frac_next;
  end

  // fraction divider
  rpr_div #(
    .CW (CW),
    .FB (FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (below),
    .divisor  (others),
    .done     (div_done),
    .quotient (div_quot)
  );

endmodule

[src/rpr_checker.sv]
// ----------------------------------------------------------------------------
// rpr_checker
// Port-level checks on the percentile rank block, bound to the top level.
// ----------------------------------------------------------------------------
`include "reader_progress_percentile_rank_assert.svh"

module rpr_checker #(
  parameter int FRACTION_BITS = rpr_pkg::FRACTION_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         command,
  input logic                         done,
  input logic [FRACTION_BITS:0]       rank_fraction
);

  import rpr_pkg::*;

  localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic accept;
  assign accept = start && !busy;

  // a fraction never exceeds one
  `RPR_ASSERT_SAME(a_frac_max, done, rank_fraction <= FRAC_ONE, "rank fraction above 1.0")

  // an accepted item keeps the block busy in the next cycle
  `RPR_ASSERT_NEXT(a_busy_after_accept, accept, busy, "busy low after accept")

  // a record item never produces a result
  `RPR_ASSERT_NEXT(a_record_silent, accept && (command == CMD_RECORD), !done ##1 !done,
    "result after record item")

  // results are single-cycle strobes that follow work
  `RPR_ASSERT_NEXT(a_done_pulse, done, !done, "done held over two cycles")

endmodule

bind reader_progress_percentile_rank rpr_checker #(
  .FRACTION_BITS (FRACTION_BITS)
) u_rpr_checker (.*);
